// ===== src/protobuf_wire_field_parser_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the protobuf wire field parser
// Implication checks clocked on clock and disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef PROTOBUF_WIRE_FIELD_PARSER_ASSERT_SVH
`define PROTOBUF_WIRE_FIELD_PARSER_ASSERT_SVH

// same-cycle implication
`define PWFP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PWFP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/pwfp_pkg.sv =====
// ---------------------------------------------------------------------------
// pwfp_pkg
// Types and constants shared by the protobuf wire field parser.
// ---------------------------------------------------------------------------
package pwfp_pkg;

   localparam int MAX_PACKET_BYTES = 65535;
   localparam int POS_W            = $clog2(MAX_PACKET_BYTES + 2);
   localparam int LEN_W            = $clog2(MAX_PACKET_BYTES + 1);
   localparam int GC_W             = 4;
   localparam int VARINT_GROUPS    = 10;
   localparam int FIX64_BYTES      = 8;
   localparam int FIX32_BYTES      = 4;

   localparam logic [2:0] WT_VARINT = 3'd0;
   localparam logic [2:0] WT_FIX64  = 3'd1;
   localparam logic [2:0] WT_LEN    = 3'd2;
   localparam logic [2:0] WT_FIX32  = 3'd5;

   typedef enum logic [6:0] {
      PH_KEY    = 7'b0000001,
      PH_VARINT = 7'b0000010,
      PH_LEN    = 7'b0000100,
      PH_PAY    = 7'b0001000,
      PH_F64    = 7'b0010000,
      PH_F32    = 7'b0100000,
      PH_DROP   = 7'b1000000
   } phase_type;

   typedef enum logic [1:0] {
      KIND_SCALAR  = 2'd0,
      KIND_HEADER  = 2'd1,
      KIND_PAYLOAD = 2'd2,
      KIND_ERROR   = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      ERR_NONE          = 4'd0,
      ERR_KEY_VARINT    = 4'd1,
      ERR_ZERO_NUMBER   = 4'd2,
      ERR_VALUE_VARINT  = 4'd3,
      ERR_FIXED64_CUT   = 4'd4,
      ERR_LENGTH_VARINT = 4'd5,
      ERR_DELIM_CUT     = 4'd6,
      ERR_FIXED32_CUT   = 4'd7,
      ERR_WIRE_TYPE     = 4'd8
   } err_type;

   // first member is the most significant: fld_num lands in the low bits
   typedef struct packed {
      err_type     error_code;
      logic        payload_last;
      logic [7:0]  payload_byte;
      logic [63:0] value;
      logic [2:0]  wtype;
      logic [31:0] fld_num;
   } rsp_data_type;

   localparam int RSP_DATA_W = $bits(rsp_data_type);

   typedef struct packed {
      logic         valid;
      kind_type     kind;
      logic         packet_end;
      rsp_data_type data;
   } result_type;

endpackage

// ===== src/pwfp_core.sv =====
// ---------------------------------------------------------------------------
// pwfp_core
// Parse state and the single-pass step logic: one packet byte in, at most
// one result out, state updated at the same clock edge.
// ---------------------------------------------------------------------------
`include "protobuf_wire_field_parser_assert.svh"

module pwfp_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          data_byte,
   input  logic                last,
   output pwfp_pkg::result_type res
);
   import pwfp_pkg::*;

   phase_type         phase_ff,  phase_in;
   logic [63:0]       acc_ff,    acc_in;
   logic [GC_W-1:0]   gc_ff,     gc_in;
   logic [31:0]       num_ff,    num_in;
   logic [2:0]        type_ff,   type_in;
   logic [LEN_W-1:0]  remain_ff, remain_in;
   logic [POS_W-1:0]  pos_ff,    pos_in;

   logic [6:0]        grp_shift;
   logic [63:0]       acc_grp;
   logic [63:0]       acc_fix;
   logic [LEN_W-1:0]  limit;
   logic [LEN_W-1:0]  remain_dec;
   logic [GC_W-1:0]   need;
   err_type           vcode;
   err_type           cut;

   assign grp_shift = {3'b000, gc_ff} * 7'd7;
   assign acc_grp   = acc_ff | (64'(data_byte[6:0]) << grp_shift[5:0]);
   assign acc_fix   = acc_ff | (64'(data_byte) << {gc_ff[2:0], 3'b000});
   assign need      = (phase_ff == PH_F64) ? GC_W'(FIX64_BYTES) : GC_W'(FIX32_BYTES);
   assign remain_dec = (remain_ff != '0) ? remain_ff - 1'b1 : remain_ff;

   always_comb begin
      unique case (phase_ff)
         PH_KEY:    vcode = ERR_KEY_VARINT;
         PH_VARINT: vcode = ERR_VALUE_VARINT;
         default:   vcode = ERR_LENGTH_VARINT;
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      gc_in     = gc_ff;
      num_in    = num_ff;
      type_in   = type_ff;
      remain_in = remain_ff;
      pos_in    = pos_ff;
      cut       = ERR_NONE;
      limit     = '0;
      res.valid = 1'b0;
      res.kind  = KIND_SCALAR;
      res.data.value        = '0;
      res.data.payload_byte = '0;
      res.data.payload_last = 1'b0;
      res.data.error_code   = ERR_NONE;

      if (step) begin
         if (pos_ff <= POS_W'(MAX_PACKET_BYTES)) begin
            pos_in = pos_ff + 1'b1;
         end
         limit = (pos_in >= POS_W'(MAX_PACKET_BYTES)) ? '0
               : LEN_W'(POS_W'(MAX_PACKET_BYTES) - pos_in);

         unique case (phase_ff)
            PH_KEY, PH_VARINT, PH_LEN: begin
               if (data_byte[7]) begin
                  acc_in = acc_grp;
                  gc_in  = gc_ff + 1'b1;
                  if (gc_in >= GC_W'(VARINT_GROUPS) || last) begin
                     if (phase_ff == PH_KEY) begin
                        num_in  = '0;
                        type_in = '0;
                     end
                     res.valid           = 1'b1;
                     res.kind            = KIND_ERROR;
                     res.data.error_code = vcode;
                     phase_in            = PH_DROP;
                  end
               end else begin
                  acc_in = '0;
                  gc_in  = '0;
                  if (phase_ff == PH_KEY) begin
                     num_in  = acc_grp[34:3];
                     type_in = acc_grp[2:0];
                     if (num_in == '0) begin
                        res.valid           = 1'b1;
                        res.kind            = KIND_ERROR;
                        res.data.error_code = ERR_ZERO_NUMBER;
                        phase_in            = PH_DROP;
                     end else begin
                        case (type_in)
                           WT_VARINT: begin
                              phase_in = PH_VARINT;
                              cut      = ERR_VALUE_VARINT;
                           end
                           WT_FIX64: begin
                              phase_in = PH_F64;
                              cut      = ERR_FIXED64_CUT;
                           end
                           WT_LEN: begin
                              phase_in = PH_LEN;
                              cut      = ERR_LENGTH_VARINT;
                           end
                           WT_FIX32: begin
                              phase_in = PH_F32;
                              cut      = ERR_FIXED32_CUT;
                           end
                           default: begin
                              res.valid           = 1'b1;
                              res.kind            = KIND_ERROR;
                              res.data.error_code = ERR_WIRE_TYPE;
                              phase_in            = PH_DROP;
                           end
                        endcase
                        // a key with nothing after it in the packet
                        if (!res.valid && last) begin
                           res.valid           = 1'b1;
                           res.kind            = KIND_ERROR;
                           res.data.error_code = cut;
                           phase_in            = PH_DROP;
                        end
                     end
                  end else if (phase_ff == PH_VARINT) begin
                     phase_in       = PH_KEY;
                     res.valid      = 1'b1;
                     res.kind       = KIND_SCALAR;
                     res.data.value = acc_grp;
                  end else begin
                     res.valid = 1'b1;
                     if ((|acc_grp[63:LEN_W]) || (acc_grp[LEN_W-1:0] > limit)) begin
                        res.kind            = KIND_ERROR;
                        res.data.error_code = ERR_DELIM_CUT;
                        phase_in            = PH_DROP;
                     end else if (acc_grp == '0) begin
                        phase_in = PH_KEY;
                        res.kind = KIND_HEADER;
                     end else if (last) begin
                        res.kind            = KIND_ERROR;
                        res.data.error_code = ERR_DELIM_CUT;
                        phase_in            = PH_DROP;
                     end else begin
                        remain_in      = acc_grp[LEN_W-1:0];
                        phase_in       = PH_PAY;
                        res.kind       = KIND_HEADER;
                        res.data.value = acc_grp;
                     end
                  end
               end
            end
            PH_PAY: begin
               remain_in = remain_dec;
               res.valid = 1'b1;
               if (remain_dec == '0) begin
                  phase_in              = PH_KEY;
                  res.kind              = KIND_PAYLOAD;
                  res.data.payload_byte = data_byte;
                  res.data.payload_last = 1'b1;
               end else if (last) begin
                  res.kind            = KIND_ERROR;
                  res.data.error_code = ERR_DELIM_CUT;
                  phase_in            = PH_DROP;
               end else begin
                  res.kind              = KIND_PAYLOAD;
                  res.data.payload_byte = data_byte;
               end
            end
            PH_F64, PH_F32: begin
               acc_in = acc_fix;
               gc_in  = gc_ff + 1'b1;
               if (gc_in >= need) begin
                  acc_in         = '0;
                  gc_in          = '0;
                  phase_in       = PH_KEY;
                  res.valid      = 1'b1;
                  res.kind       = KIND_SCALAR;
                  res.data.value = acc_fix;
               end else if (last) begin
                  res.valid           = 1'b1;
                  res.kind            = KIND_ERROR;
                  res.data.error_code = (phase_ff == PH_F64) ? ERR_FIXED64_CUT
                                                             : ERR_FIXED32_CUT;
                  phase_in            = PH_DROP;
               end
            end
            PH_DROP: begin
               phase_in = PH_DROP;
            end
            default: begin
               phase_in = PH_KEY;
            end
         endcase

         // every packet end starts the next packet clean
         if (last) begin
            phase_in  = PH_KEY;
            acc_in    = '0;
            gc_in     = '0;
            remain_in = '0;
            pos_in    = '0;
         end
      end

      res.packet_end    = last;
      res.data.fld_num  = num_in;
      res.data.wtype    = type_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_KEY;
         acc_ff    <= '0;
         gc_ff     <= '0;
         num_ff    <= '0;
         type_ff   <= '0;
         remain_ff <= '0;
         pos_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         acc_ff    <= acc_in;
         gc_ff     <= gc_in;
         num_ff    <= num_in;
         type_ff   <= type_in;
         remain_ff <= remain_in;
         pos_ff    <= pos_in;
      end
   end

   `PWFP_ASSERT_NEXT(a_last_clears, step && last,
      phase_ff == PH_KEY && pos_ff == '0 && gc_ff == '0, "packet end left parse state")
   `PWFP_ASSERT_NOW(a_pay_nonzero, phase_ff == PH_PAY,
      remain_ff != '0, "payload phase with no bytes remaining")
   `PWFP_ASSERT_NOW(a_varint_groups,
      phase_ff == PH_KEY || phase_ff == PH_VARINT || phase_ff == PH_LEN,
      gc_ff < GC_W'(VARINT_GROUPS), "varint group count overran")
   `PWFP_ASSERT_NEXT(a_error_drops, step && res.valid && res.kind == KIND_ERROR,
      phase_ff == PH_DROP || phase_ff == PH_KEY, "error did not drop the packet")

endmodule

// ===== src/protobuf_wire_field_parser.sv =====
// ---------------------------------------------------------------------------
// protobuf_wire_field_parser
// Splits a byte stream of protobuf packets into wire fields and errors.
// ---------------------------------------------------------------------------
// Takes one packet byte per cycle and gives one result per byte that causes
// one: a finished scalar field, a delimited header, a payload byte or an
// error. Requests pass an input register, the step logic and a result
// register, so a result is held in the result register once its request
// has been stepped, and stays valid until it is taken; the step logic updates
// all parse state at once, which sets the sustained rate at one byte per
// clock while the result side keeps taking.
// After an error the remaining bytes of that packet give no result. No
// initialization pass is needed after reset.
module protobuf_wire_field_parser (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // [7:0] data_byte
   input  logic                            req_tlast,  // last_in_packet
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [31:0] fld_num, [34:32] wtype, [98:35] value,
   // [106:99] payload_byte, [107] payload_last, [111:108] error_code
   output logic [pwfp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]                      rsp_tuser,  // [1:0] kind
   output logic                            rsp_tlast   // packet_end
);
   import pwfp_pkg::*;

   logic         in_valid_ff, in_valid_in;
   logic [7:0]   in_byte_ff;
   logic         in_last_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_data_type out_data_ff;
   kind_type     out_kind_ff;
   logic         out_end_ff;
   logic         out_free;
   logic         step;
   result_type   res;

   assign out_free    = !out_valid_ff || rsp_tready;
   assign step        = in_valid_ff && out_free;
   assign req_tready  = !in_valid_ff || out_free;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;
   assign out_valid_in = out_free ? (step && res.valid) : out_valid_ff;

   pwfp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (in_byte_ff),
      .last      (in_last_ff),
      .res       (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // hold the request until the step logic takes it
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (step && res.valid) begin
         out_data_ff <= res.data;
         out_kind_ff <= res.kind;
         out_end_ff  <= res.packet_end;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_end_ff;

endmodule

// ===== dv/testbench.sv =====
// ---------------------------------------------------------------------------
// Protobuf wire field parser testbench
// Streams packets into the parser one byte per request and predicts every
// field, header, payload byte and error it reports. Directed packets hit
// the edge cases, and random packets mix well-formed fields with broken ones.
// ---------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import pwfp_pkg::*;

   typedef struct {
      kind_type     kind;
      rsp_data_type data;
      bit           packet_end;
   } parsed_field_type;

   class field_scoreboard;
      parsed_field_type expected_fields[$];
      int               mismatches;

      phase_type     phase;
      bit [63:0]     accum;
      bit [3:0]      groups;
      bit [31:0]     cur_number;
      bit [2:0]      cur_type;
      bit [15:0]     remaining;
      int unsigned   position;
      bit            emitted;

      function new();
         phase      = PH_KEY;
         accum      = '0;
         groups     = '0;
         cur_number = '0;
         cur_type   = '0;
         remaining  = '0;
         position   = 0;
         mismatches = 0;
         emitted    = 1'b0;
      endfunction

      function int pending();
         return expected_fields.size();
      endfunction

      function void emit(kind_type k, bit [63:0] v, bit [7:0] pb, bit pl, err_type e,
                         bit last_byte);
         parsed_field_type f;
         f.kind              = k;
         f.data.fld_num      = cur_number;
         f.data.wtype        = cur_type;
         f.data.value        = v;
         f.data.payload_byte = pb;
         f.data.payload_last = pl;
         f.data.error_code   = e;
         f.packet_end        = last_byte;
         expected_fields.insert(expected_fields.size(), f);
         emitted = 1'b1;
      endfunction

      function void fail(err_type e, bit last_byte);
         phase = PH_DROP;
         emit(KIND_ERROR, '0, '0, 1'b0, e, last_byte);
      endfunction

      // advance the parse state by one accepted byte
      function void parse_byte(bit [7:0] b, bit last_byte);
         err_type   code;
         err_type   cut;
         bit [63:0] v;
         bit [63:0] limit;
         int        need;
         emitted = 1'b0;
         cut     = ERR_NONE;
         if (position <= MAX_PACKET_BYTES) position++;
         case (phase)
            PH_KEY, PH_VARINT, PH_LEN: begin
               code = (phase == PH_KEY) ? ERR_KEY_VARINT :
                      (phase == PH_VARINT) ? ERR_VALUE_VARINT : ERR_LENGTH_VARINT;
               accum |= 64'(b[6:0]) << (7 * groups);
               if (b[7]) begin
                  groups++;
                  if (groups >= VARINT_GROUPS || last_byte) begin
                     if (code == ERR_KEY_VARINT) begin
                        cur_number = '0;
                        cur_type   = '0;
                     end
                     fail(code, last_byte);
                  end
               end else begin
                  v      = accum;
                  accum  = '0;
                  groups = '0;
                  if (phase == PH_KEY) begin
                     cur_number = v[34:3];
                     cur_type   = v[2:0];
                     if (cur_number == 0) begin
                        fail(ERR_ZERO_NUMBER, last_byte);
                     end else begin
                        case (cur_type)
                           WT_VARINT: begin
                              phase = PH_VARINT;
                              cut   = ERR_VALUE_VARINT;
                           end
                           WT_FIX64: begin
                              phase = PH_F64;
                              cut   = ERR_FIXED64_CUT;
                           end
                           WT_LEN: begin
                              phase = PH_LEN;
                              cut   = ERR_LENGTH_VARINT;
                           end
                           WT_FIX32: begin
                              phase = PH_F32;
                              cut   = ERR_FIXED32_CUT;
                           end
                           default: fail(ERR_WIRE_TYPE, last_byte);
                        endcase
                        if (!emitted && last_byte) fail(cut, last_byte);
                     end
                  end else if (phase == PH_VARINT) begin
                     phase = PH_KEY;
                     emit(KIND_SCALAR, v, '0, 1'b0, ERR_NONE, last_byte);
                  end else begin
                     limit = (position >= MAX_PACKET_BYTES) ? 64'd0 :
                             64'(MAX_PACKET_BYTES - position);
                     if (v > limit) begin
                        fail(ERR_DELIM_CUT, last_byte);
                     end else if (v == 0) begin
                        phase = PH_KEY;
                        emit(KIND_HEADER, '0, '0, 1'b0, ERR_NONE, last_byte);
                     end else if (last_byte) begin
                        fail(ERR_DELIM_CUT, last_byte);
                     end else begin
                        remaining = v[15:0];
                        phase     = PH_PAY;
                        emit(KIND_HEADER, v, '0, 1'b0, ERR_NONE, last_byte);
                     end
                  end
               end
            end
            PH_PAY: begin
               if (remaining != 0) remaining--;
               if (remaining == 0) begin
                  phase = PH_KEY;
                  emit(KIND_PAYLOAD, '0, b, 1'b1, ERR_NONE, last_byte);
               end else if (last_byte) begin
                  fail(ERR_DELIM_CUT, last_byte);
               end else begin
                  emit(KIND_PAYLOAD, '0, b, 1'b0, ERR_NONE, last_byte);
               end
            end
            PH_F64, PH_F32: begin
               need = (phase == PH_F64) ? FIX64_BYTES : FIX32_BYTES;
               accum |= 64'(b) << (8 * groups[2:0]);
               groups++;
               if (groups >= need) begin
                  v      = accum;
                  accum  = '0;
                  groups = '0;
                  phase  = PH_KEY;
                  emit(KIND_SCALAR, v, '0, 1'b0, ERR_NONE, last_byte);
               end else if (last_byte) begin
                  fail((need == FIX64_BYTES) ? ERR_FIXED64_CUT : ERR_FIXED32_CUT,
                       last_byte);
               end
            end
            default: ;
         endcase
         // every packet end returns to expecting a key
         if (last_byte) begin
            phase     = PH_KEY;
            accum     = '0;
            groups    = '0;
            remaining = '0;
            position  = 0;
         end
      endfunction

      function void check_field(kind_type k, rsp_data_type d, bit last_byte);
         parsed_field_type e;
         if (expected_fields.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: kind=%0d num=%h err=%0d end=%0d",
                        k, d.fld_num, d.error_code, last_byte);
            return;
         end
         e = expected_fields.pop_front();
         if (e.kind !== k || e.data.fld_num !== d.fld_num ||
             e.data.wtype !== d.wtype || e.data.value !== d.value ||
             e.data.payload_byte !== d.payload_byte ||
             e.data.payload_last !== d.payload_last ||
             e.data.error_code !== d.error_code || e.packet_end !== last_byte) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display({"mismatch exp: kind=%0d num=%h wt=%0d val=%h",
                         " pb=%h pl=%0d err=%0d end=%0d"},
                        e.kind, e.data.fld_num, e.data.wtype, e.data.value,
                        e.data.payload_byte, e.data.payload_last, e.data.error_code,
                        e.packet_end);
               $display({"         got: kind=%0d num=%h wt=%0d val=%h",
                         " pb=%h pl=%0d err=%0d end=%0d"},
                        k, d.fld_num, d.wtype, d.value, d.payload_byte,
                        d.payload_last, d.error_code, last_byte);
            end
         end
      endfunction
   endclass

   localparam logic [2:0] WT_SGROUP = 3'd3;
   localparam logic [2:0] WT_EGROUP = 3'd4;
   localparam logic [2:0] WT_RSVD6  = 3'd6;
   localparam logic [2:0] WT_RSVD7  = 3'd7;

   typedef enum {READY_ALWAYS, READY_COIN, READY_PERIODIC, READY_STALLS} ready_mode_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  rsp_tlast;

   field_scoreboard sb = new();
   bit [7:0]        packet_bytes[$];
   int              burst_left = 0;
   ready_mode_type  ready_mode = READY_ALWAYS;
   int              ready_mode_left = 0;
   int              ready_phase = 0;
   int              stall_left = 0;

   protobuf_wire_field_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.parse_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready)
            sb.check_field(kind_type'(rsp_tuser), rsp_data_type'(rsp_tdata), rsp_tlast);
      end
   end

   // result side switches between its own stall patterns
   always @(negedge clock) begin
      if (ready_mode_left == 0) begin
         ready_mode      = ready_mode_type'($urandom_range(0, 3));
         ready_mode_left = $urandom_range(16, 160);
      end else begin
         ready_mode_left--;
      end
      ready_phase++;
      case (ready_mode)
         READY_ALWAYS:   rsp_tready <= 1'b1;
         READY_COIN:     rsp_tready <= 1'($urandom_range(0, 1));
         READY_PERIODIC: rsp_tready <= (ready_phase % 3) != 0;
         default: begin
            if (stall_left > 0) begin
               stall_left--;
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
               if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 8);
            end
         end
      endcase
   end

   function automatic void add_byte(bit [7:0] b);
      packet_bytes.insert(packet_bytes.size(), b);
   endfunction

   function automatic bit [63:0] rand_bits(int n);
      bit [63:0] v;
      v = {$urandom, $urandom};
      if (n < 64) v &= (64'd1 << n) - 64'd1;
      return v;
   endfunction

   function automatic void add_varint(bit [63:0] v, int pad);
      bit [63:0] x;
      int        groups;
      x      = v;
      groups = 1;
      while (x >= 128) begin
         add_byte({1'b1, x[6:0]});
         x = x >> 7;
         groups++;
      end
      // non-minimal encoding: extra continuation groups, still within ten
      repeat ((pad > VARINT_GROUPS - groups) ? VARINT_GROUPS - groups : pad) begin
         add_byte({1'b1, x[6:0]});
         x = '0;
      end
      add_byte({1'b0, x[6:0]});
   endfunction

   function automatic void add_key(bit [60:0] num, bit [2:0] wt, int pad);
      add_varint({num, wt}, pad);
   endfunction

   function automatic bit [60:0] rand_number();
      bit [60:0] n;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: n = 61'($urandom_range(1, 15));
         5, 6:          n = 61'(rand_bits($urandom_range(5, 29)));
         7:             n = 61'($urandom);
         default:       n = 61'(rand_bits(61));
      endcase
      if (n[31:0] == 0) n[0] = 1'b1;
      return n;
   endfunction

   function automatic void add_random_field();
      bit [60:0] num;
      int        pad;
      int        len;
      bit [2:0]  wt;
      num = rand_number();
      pad = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
      case ($urandom_range(0, 99)) inside
         [0:24]: begin
            add_key(num, WT_VARINT, pad);
            add_varint(rand_bits($urandom_range(0, 64)), $urandom_range(0, 1));
         end
         [25:39]: begin
            add_key(num, WT_FIX64, pad);
            repeat (FIX64_BYTES) add_byte(8'($urandom));
         end
         [40:54]: begin
            add_key(num, WT_FIX32, pad);
            repeat (FIX32_BYTES) add_byte(8'($urandom));
         end
         [55:79]: begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 300)
                                               : $urandom_range(0, 10);
            add_key(num, WT_LEN, pad);
            add_varint(64'(len), pad);
            repeat (len) add_byte(8'($urandom));
         end
         [80:84]: begin
            case ($urandom_range(0, 3))
               0:       wt = WT_SGROUP;
               1:       wt = WT_EGROUP;
               2:       wt = WT_RSVD6;
               default: wt = WT_RSVD7;
            endcase
            add_key(num, wt, pad);
            repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
         end
         [85:87]: begin
            // number whose low 32 bits are all zero
            num = $urandom_range(0, 1) ? 61'd0 : {29'($urandom_range(1, 1000)), 32'd0};
            add_key(num, 3'($urandom), 0);
         end
         [88:90]: begin
            case ($urandom_range(0, 2))
               0:       ;
               1:       add_key(num, WT_VARINT, 0);
               default: add_key(num, WT_LEN, 0);
            endcase
            repeat ($urandom_range(10, 12)) add_byte({1'b1, 7'($urandom)});
         end
         [91:94]: begin
            add_key(num, WT_LEN, pad);
            if ($urandom_range(0, 1))
               add_varint(64'(MAX_PACKET_BYTES + $urandom_range(0, 1000)), 0);
            else
               add_varint(rand_bits(64) | 64'h1_0000, 0);
            add_byte(8'($urandom));
         end
         default: repeat ($urandom_range(1, 5)) add_byte(8'($urandom));
      endcase
   endfunction

   task automatic send_byte(input bit [7:0] b, input bit last_byte);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last_byte;
      do @(posedge clock); while (req_tready !== 1'b1);
      @(negedge clock);
   endtask

   task automatic send_packet();
      foreach (packet_bytes[i]) send_byte(packet_bytes[i], i == packet_bytes.size() - 1);
      packet_bytes.delete();
   endtask

   // hold requests until every predicted result is out
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(negedge clock); while (sb.pending() != 0);
   endtask

   initial begin
      #20_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int random_bytes;
      int cut;
      random_bytes = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // scalar, fixed, delimited and zero-length fields, the last at packet end
      packet_bytes = '{8'h08, 8'h96, 8'h01, 8'h0D, 8'h78, 8'h56, 8'h34, 8'h12,
                       8'h09, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                       8'h0A, 8'h03, 8'h00, 8'h80, 8'hFF, 8'h12, 8'h00};
      send_packet();
      // ten-group varints: all ones, high bits of the tenth group lost; then the largest field number
      add_key(61'd1, WT_VARINT, 0);
      add_varint(64'hFFFF_FFFF_FFFF_FFFF, 0);
      add_key(61'd1, WT_VARINT, 0);
      repeat (9) add_byte(8'hFF);
      add_byte(8'h7F);
      add_key(61'hFFFF_FFFF, WT_VARINT, 0);
      add_varint(64'd0, 0);
      send_packet();
      // overlong key, then dropped bytes
      packet_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                       8'hFF, 8'hFF, 8'h05};
      send_packet();
      packet_bytes = '{8'h00, 8'h01};
      send_packet();
      add_key({29'd1, 32'd0}, WT_VARINT, 0);
      send_packet();
      packet_bytes = '{8'h0B, 8'h01};
      send_packet();
      // valid key on the last byte, one per wire type
      packet_bytes = '{8'h08};
      send_packet();
      packet_bytes = '{8'h09};
      send_packet();
      packet_bytes = '{8'h0A};
      send_packet();
      packet_bytes = '{8'h0D};
      send_packet();
      packet_bytes = '{8'h88};
      send_packet();
      packet_bytes = '{8'h08, 8'hFF};
      send_packet();
      packet_bytes = '{8'h09, 8'h01, 8'h02};
      send_packet();
      packet_bytes = '{8'h0D, 8'h01};
      send_packet();
      packet_bytes = '{8'h0A, 8'h05, 8'hAA};
      send_packet();
      packet_bytes = '{8'h0A, 8'h02};
      send_packet();
      add_key(61'd2, WT_LEN, 0);
      repeat (10) add_byte(8'hFF);
      add_byte(8'h00);
      send_packet();
      // length exactly at the packet limit, then one over
      add_key(61'd1, WT_LEN, 0);
      add_varint(64'(MAX_PACKET_BYTES - 4), 0);
      add_byte(8'h01);
      add_byte(8'h02);
      add_byte(8'h03);
      send_packet();
      add_key(61'd1, WT_LEN, 0);
      add_varint(64'(MAX_PACKET_BYTES - 3), 0);
      add_byte(8'h00);
      send_packet();
      wait_drained();

      while (random_bytes < 400) begin
         repeat ($urandom_range(1, 6)) add_random_field();
         if ($urandom_range(0, 3) == 0 && packet_bytes.size() > 1) begin
            cut = $urandom_range(1, packet_bytes.size() - 1);
            while (packet_bytes.size() > cut) void'(packet_bytes.pop_back());
         end
         random_bytes += packet_bytes.size();
         send_packet();
         if ($urandom_range(0, 19) == 0) wait_drained();
      end

      wait_drained();
      repeat (8) @(negedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
